// File: src/keyed_max_priority_queue_assert.svh
// Assertion macros shared by the keyed max priority queue RTL.
`ifndef KEYED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define KEYED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define KMPQ_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Check a consequence in the same cycle as its cause.
`define KMPQ_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define KMPQ_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/kmpq_pkg.sv
// Shared constants and types of the keyed max priority queue.
package kmpq_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 64;
	localparam int OP_W    = 2;
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	// Input request layout in s_tdata
	localparam int IN_KEY_LO = 0;
	localparam int IN_VAL_LO = IN_KEY_LO + KEY_W;
	localparam int IN_END_LO = IN_VAL_LO + VAL_W;
	localparam int IN_DATA_W = IN_END_LO + KEY_W;

	// Result layout in m_tdata
	localparam int OUT_KEY_LO = 0;
	localparam int OUT_VAL_LO = OUT_KEY_LO + KEY_W;
	localparam int OUT_DATA_W = OUT_VAL_LO + VAL_W;

	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
		KEY_W'((64'd1 << KEY_BITS) - 64'd1);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [OP_W-1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_RNG = 2'd2
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Outcome of comparing one stored key against the request bounds
	typedef struct packed {
		logic eq_lo;
		logic lt_lo;
		logic le_hi;
	} cmp_t;

endpackage

// File: src/kmpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word and register one read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/kmpq_cmp.sv
// Key comparator shared by every table scan.
module kmpq_cmp (
	input  logic [kmpq_pkg::KEY_W-1:0] entry_key,
	input  logic [kmpq_pkg::KEY_W-1:0] lo_key,
	input  logic [kmpq_pkg::KEY_W-1:0] hi_key,
	output kmpq_pkg::cmp_t             res
);
	import kmpq_pkg::*;

	// Compare the stored key against both bounds
	always_comb begin
		res.eq_lo = (entry_key == lo_key);
		res.lt_lo = (entry_key < lo_key);
		res.le_hi = (entry_key <= hi_key);
	end

endmodule

// File: src/keyed_max_priority_queue.sv
// Top level of the keyed max priority queue: sequencer, entry RAM and result register.
//
// The table holds up to CAPACITY unique keys with value words, largest key in
// slot 0, in a RAM with one write and one registered read port. One request is
// handled at a time; s_tready is high only while the sequencer is idle. Every
// step reads one slot, and scan steps run it through the single key comparator,
// so the cost is set by that read port: an enqueue scans to the insert point,
// moves each later entry down one slot and writes the new one; a dequeue emits
// the head and moves each later entry up one slot; a range query scans the
// table and also waits while the consumer stalls a result. The RAM needs no
// clearing after reset: only data from slots below the fill count is ever used.
// Results pass through one output register, so a finished result may wait
// while the next request is taken.
module keyed_max_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// bits from low: item_key[31:0], item_value[95:32], range_end[127:96]
	input  logic [kmpq_pkg::IN_DATA_W-1:0]    s_tdata,
	// bits from low: operation[1:0]
	input  logic [kmpq_pkg::OP_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// bits from low: out_key[31:0], out_value[95:32]
	output logic [kmpq_pkg::OUT_DATA_W-1:0]   m_tdata,
	// bits from low: success[0]
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import kmpq_pkg::*;

	`include "keyed_max_priority_queue_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ_SCAN,
		ST_ENQ_SHIFT,
		ST_ENQ_PUT,
		ST_DEQ_HEAD,
		ST_DEQ_SHIFT,
		ST_RNG_SCAN,
		ST_FAIL
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   pos_q, pos_d;
	logic [KEY_W-1:0]   key_q, key_d;
	logic [VAL_W-1:0]   val_q, val_d;
	logic [KEY_W-1:0]   hi_q, hi_d;
	logic               pend_q, pend_d;
	entry_t             pend_ent_q, pend_ent_d;
	logic               out_valid_q, out_valid_d;
	logic               out_ok_q, out_ok_d;
	logic               out_last_q, out_last_d;
	entry_t             out_ent_q, out_ent_d;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_ent;
	cmp_t               cmp_res;

	logic               accept;
	logic               can_push;
	logic               at_end;
	logic               emit;
	logic               emit_ok;
	logic               emit_last;
	entry_t             emit_ent;
	entry_t             new_ent;

	kmpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_ent = ram_rdata;

	kmpq_cmp u_cmp (
		.entry_key(rd_ent.key),
		.lo_key   (key_q),
		.hi_key   (hi_q),
		.res      (cmp_res)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_push = !out_valid_q || m_tready;
	assign at_end   = (idx_q == count_q);
	assign new_ent  = '{key: key_q, value: val_q};

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_ent_q.value, out_ent_q.key};

	// Sequence the scan, shift and emit steps
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		key_d      = key_q;
		val_d      = val_q;
		hi_d       = hi_q;
		pend_d     = pend_q;
		pend_ent_d = pend_ent_q;
		ram_we     = 1'b0;
		ram_waddr  = idx_q[IDX_W-1:0];
		ram_wdata  = new_ent;
		ram_raddr  = idx_q[IDX_W-1:0];
		emit       = 1'b0;
		emit_ok    = 1'b0;
		emit_last  = 1'b1;
		emit_ent   = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_d     = s_tdata[IN_KEY_LO +: KEY_W] & KEY_MASK;
					val_d     = s_tdata[IN_VAL_LO +: VAL_W];
					hi_d      = s_tdata[IN_END_LO +: KEY_W] & KEY_MASK;
					idx_d     = '0;
					pend_d    = 1'b0;
					ram_raddr = '0;
					unique case (op_t'(s_tuser))
						OP_ENQ: state_d = ST_ENQ_SCAN;
						OP_DEQ: state_d = (count_q == '0) ? ST_FAIL : ST_DEQ_HEAD;
						OP_RNG: state_d = ST_RNG_SCAN;
						default: state_d = ST_FAIL;
					endcase
				end
			end

			ST_ENQ_SCAN: begin
				if (!at_end && cmp_res.eq_lo) begin
					// Key present: replace its value and echo
					ram_we    = 1'b1;
					ram_waddr = idx_q[IDX_W-1:0];
					if (can_push) begin
						emit     = 1'b1;
						emit_ok  = 1'b1;
						emit_ent = new_ent;
						state_d  = ST_IDLE;
					end
				end else if (at_end || cmp_res.lt_lo) begin
					// Insert point found
					if (count_q == CAP_CNT) begin
						state_d = ST_FAIL;
					end else begin
						pos_d = idx_q;
						if (at_end) begin
							state_d = ST_ENQ_PUT;
						end else begin
							idx_d     = count_q - 1'b1;
							ram_raddr = IDX_W'(count_q - 1'b1);
							state_d   = ST_ENQ_SHIFT;
						end
					end
				end else begin
					idx_d     = idx_q + 1'b1;
					ram_raddr = IDX_W'(idx_q + 1'b1);
				end
			end

			ST_ENQ_SHIFT: begin
				// Move one entry a slot toward the tail
				ram_we    = 1'b1;
				ram_waddr = IDX_W'(idx_q + 1'b1);
				ram_wdata = rd_ent;
				if (idx_q == pos_q) begin
					state_d = ST_ENQ_PUT;
				end else begin
					idx_d     = idx_q - 1'b1;
					ram_raddr = IDX_W'(idx_q - 1'b1);
				end
			end

			ST_ENQ_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				if (can_push) begin
					emit     = 1'b1;
					emit_ok  = 1'b1;
					emit_ent = new_ent;
					count_d  = count_q + 1'b1;
					state_d  = ST_IDLE;
				end
			end

			ST_DEQ_HEAD: begin
				if (can_push) begin
					emit     = 1'b1;
					emit_ok  = 1'b1;
					emit_ent = rd_ent;
					if (count_q == CNT_W'(1)) begin
						count_d = count_q - 1'b1;
						state_d = ST_IDLE;
					end else begin
						idx_d     = CNT_W'(1);
						ram_raddr = IDX_W'(1);
						state_d   = ST_DEQ_SHIFT;
					end
				end
			end

			ST_DEQ_SHIFT: begin
				// Move one entry a slot toward the head
				ram_we    = 1'b1;
				ram_waddr = IDX_W'(idx_q - 1'b1);
				ram_wdata = rd_ent;
				if (idx_q == count_q - 1'b1) begin
					count_d = count_q - 1'b1;
					state_d = ST_IDLE;
				end else begin
					idx_d     = idx_q + 1'b1;
					ram_raddr = IDX_W'(idx_q + 1'b1);
				end
			end

			ST_RNG_SCAN: begin
				if (at_end || cmp_res.lt_lo) begin
					// Keys only fall from here: close the run
					if (can_push) begin
						emit     = 1'b1;
						emit_ok  = pend_q;
						emit_ent = pend_q ? pend_ent_q : '0;
						state_d  = ST_IDLE;
					end
				end else if (cmp_res.le_hi) begin
					// Match: flush the held one, hold this one
					if (!pend_q || can_push) begin
						emit       = pend_q;
						emit_ok    = 1'b1;
						emit_last  = 1'b0;
						emit_ent   = pend_ent_q;
						pend_d     = 1'b1;
						pend_ent_d = rd_ent;
						idx_d      = idx_q + 1'b1;
						ram_raddr  = IDX_W'(idx_q + 1'b1);
					end
				end else begin
					idx_d     = idx_q + 1'b1;
					ram_raddr = IDX_W'(idx_q + 1'b1);
				end
			end

			ST_FAIL: begin
				if (can_push) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase

		// Load or drain the result register
		out_valid_d = out_valid_q;
		out_ok_d    = out_ok_q;
		out_last_d  = out_last_q;
		out_ent_d   = out_ent_q;
		if (emit) begin
			out_valid_d = 1'b1;
			out_ok_d    = emit_ok;
			out_last_d  = emit_last;
			out_ent_d   = emit_ent;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end
	end

	// Hold state, counters and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			pos_q       <= pos_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		key_q      <= key_d;
		val_q      <= val_d;
		hi_q       <= hi_d;
		pend_ent_q <= pend_ent_d;
		out_ok_q   <= out_ok_d;
		out_last_q <= out_last_d;
		out_ent_q  <= out_ent_d;
	end

	`KMPQ_ALWAYS(a_count_bound, count_q <= CAP_CNT, "fill count above capacity")
	`KMPQ_NEXT(a_busy_after_accept, accept, !s_tready, "ready right after an accepted request")
	`KMPQ_IMPLY(a_no_write_idle, ram_we, state_q != ST_IDLE, "table written while idle")
	`KMPQ_IMPLY(a_put_not_full, state_q == ST_ENQ_PUT, count_q < CAP_CNT, "insert into a full table")
	`KMPQ_NEXT(a_count_step, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1, "fill count jumped")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the keyed max priority queue: a directed table, then random requests checked against a table model.
module testbench;
	import kmpq_pkg::*;

	// Operation code with no meaning; the block must reject it
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam int RAND_ITEMS  = 133;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             last;
	} result_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] rend;
		int               reps;
		logic [KEY_W-1:0] stride;
		logic             fixed;
		result_t          want;
	} req_t;

	// Rejected request: no entry, last set
	localparam result_t REJECT = '{ok: 1'b0, key: '0, value: '0, last: 1'b1};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	// Typed expectation travelling with the request on the bus
	logic    drv_fixed;
	result_t drv_want;

	// Table model
	logic [KEY_W-1:0] tbl_key [CAPACITY];
	logic [VAL_W-1:0] tbl_val [CAPACITY];
	int               tbl_cnt = 0;
	result_t          model_out [$];
	result_t          expected_q [$];

	int errors = 0;
	int acc_count = 0;
	bit hold_request = 1'b0;
	bit no_idle = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	keyed_max_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	task automatic report(input string what, input logic [VAL_W-1:0] got,
		input logic [VAL_W-1:0] want);
		$display("ERROR %0t ns: %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	function automatic result_t res(input logic ok, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v, input logic l);
		res = '{ok: ok, key: k, value: v, last: l};
	endfunction

	// Apply one request to the table model, leaving its results in model_out
	task automatic model_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key_in,
		input logic [VAL_W-1:0] val, input logic [KEY_W-1:0] end_in);
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] hi;
		int pos;
		bit hit;
		k = key_in & KEY_MASK;
		hi = end_in & KEY_MASK;
		hit = 1'b0;
		model_out.delete();
		case (op)
			OP_ENQ: begin
				for (int i = 0; i < tbl_cnt; i++)
					if (!hit && tbl_key[i] == k) begin
						tbl_val[i] = val;
						hit = 1'b1;
					end
				if (hit) begin
					model_out.push_back(res(1'b1, k, val, 1'b1));
				end else if (tbl_cnt >= CAPACITY) begin
					model_out.push_back(REJECT);
				end else begin
					pos = 0;
					while (pos < tbl_cnt && tbl_key[pos] > k)
						pos++;
					for (int i = tbl_cnt; i > pos; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_val[i] = tbl_val[i-1];
					end
					tbl_key[pos] = k;
					tbl_val[pos] = val;
					tbl_cnt++;
					model_out.push_back(res(1'b1, k, val, 1'b1));
				end
			end
			OP_DEQ: begin
				if (tbl_cnt == 0) begin
					model_out.push_back(REJECT);
				end else begin
					model_out.push_back(res(1'b1, tbl_key[0], tbl_val[0], 1'b1));
					for (int i = 1; i < tbl_cnt; i++) begin
						tbl_key[i-1] = tbl_key[i];
						tbl_val[i-1] = tbl_val[i];
					end
					tbl_cnt--;
				end
			end
			OP_RNG: begin
				for (int i = 0; i < tbl_cnt; i++)
					if (tbl_key[i] >= k && tbl_key[i] <= hi)
						model_out.push_back(res(1'b1, tbl_key[i], tbl_val[i], 1'b0));
				if (model_out.size() == 0)
					model_out.push_back(REJECT);
				else
					model_out[model_out.size()-1].last = 1'b1;
			end
			default: begin
				model_out.push_back(REJECT);
			end
		endcase
	endtask

	// Predict on accepted requests, check accepted results against the oldest expectation
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n && s_tvalid && s_tready) begin
			acc_count++;
			model_request(s_tuser, s_tdata[IN_KEY_LO +: KEY_W], s_tdata[IN_VAL_LO +: VAL_W],
				s_tdata[IN_END_LO +: KEY_W]);
			if (drv_fixed)
				expected_q.push_back(drv_want);
			else
				foreach (model_out[i])
					expected_q.push_back(model_out[i]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = res(m_tuser, m_tdata[OUT_KEY_LO +: KEY_W], m_tdata[OUT_VAL_LO +: VAL_W],
				m_tlast);
			if (expected_q.size() == 0) begin
				report("result with nothing expected", VAL_W'(got.key), '0);
			end else begin
				want = expected_q.pop_front();
				if (got.ok !== want.ok)
					report("success", VAL_W'(got.ok), VAL_W'(want.ok));
				if (got.key !== want.key)
					report("out_key", VAL_W'(got.key), VAL_W'(want.key));
				if (got.value !== want.value)
					report("out_value", got.value, want.value);
				if (got.last !== want.last)
					report("last", VAL_W'(got.last), VAL_W'(want.last));
			end
		end
	end

	// Drive the result side ready: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until it is taken
	task automatic send_req(input req_t r);
		int seen;
		s_tvalid <= 1'b1;
		s_tdata <= {r.rend, r.value, r.key};
		s_tuser <= r.op;
		drv_fixed <= r.fixed;
		drv_want <= r.want;
		seen = acc_count;
		do
			@(negedge clk);
		while (acc_count == seen);
	endtask

	task automatic maybe_gap();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	function automatic req_t row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v, input logic [KEY_W-1:0] e, input int reps,
		input logic [KEY_W-1:0] stride, input logic fixed, input result_t want);
		row = '{op: op, key: k, value: v, rend: e, reps: reps, stride: stride,
			fixed: fixed, want: want};
	endfunction

	// Mostly keys from a small scattered pool so updates hit, sometimes extremes or anything
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			pick_key = KEY_W'(32'h9E37_79B9 * $urandom_range(0, 23));
		else if (roll < 65)
			pick_key = '1;
		else if (roll < 70)
			pick_key = '0;
		else
			pick_key = $urandom;
	endfunction

	// Random request; phase 0 leans to filling, phase 1 to draining, phase 2 is mixed
	function automatic req_t rand_req(input int phase);
		req_t r;
		int roll;
		int w_enq;
		int w_deq;
		logic [KEY_W-1:0] a;
		logic [KEY_W-1:0] b;
		w_enq = (phase == 0) ? 65 : (phase == 1) ? 20 : 40;
		w_deq = (phase == 0) ? 10 : (phase == 1) ? 50 : 25;
		r = row(OP_ENQ, pick_key(), {$urandom, $urandom}, pick_key(), 1, '0, 1'b0, REJECT);
		roll = $urandom_range(0, 99);
		if (roll < w_enq)
			r.op = OP_ENQ;
		else if (roll < w_enq + w_deq)
			r.op = OP_DEQ;
		else if (roll < 95)
			r.op = OP_RNG;
		else
			r.op = OP_NOP;
		if (r.op == OP_RNG) begin
			roll = $urandom_range(0, 9);
			a = pick_key();
			b = pick_key();
			if (roll < 2) begin
				r.key = '0;
				r.rend = '1;
			end else if (roll < 8) begin
				r.key = (a < b) ? a : b;
				r.rend = (a < b) ? b : a;
			end
		end
		return r;
	endfunction

	initial begin : stimulus
		req_t plan [$];
		req_t r;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		drv_fixed = 1'b0;
		drv_want = REJECT;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table: empty cases, extremes, update, full table, widest range
		plan.push_back(row(OP_DEQ, '0, '0, '0, 1, '0, 1'b1, REJECT));
		plan.push_back(row(OP_RNG, '0, '0, '1, 1, '0, 1'b1, REJECT));
		plan.push_back(row(OP_NOP, '1, '1, '1, 1, '0, 1'b1, REJECT));
		plan.push_back(row(OP_ENQ, '1, '1, '0, 1, '0, 1'b1, res(1'b1, '1, '1, 1'b1)));
		plan.push_back(row(OP_ENQ, '0, '0, '1, 1, '0, 1'b1, res(1'b1, '0, '0, 1'b1)));
		plan.push_back(row(OP_ENQ, 32'h8000_0000, 64'h5555_5555_5555_5555, '0, 1, '0, 1'b1,
			res(1'b1, 32'h8000_0000, 64'h5555_5555_5555_5555, 1'b1)));
		plan.push_back(row(OP_ENQ, '0, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1, '0, 1'b1,
			res(1'b1, '0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1)));
		plan.push_back(row(OP_RNG, '0, '0, '1, 1, '0, 1'b0, REJECT));
		plan.push_back(row(OP_RNG, 32'h10, '0, 32'h5, 1, '0, 1'b1, REJECT));
		plan.push_back(row(OP_ENQ, 32'h0100_0000, 64'h0123_4567_89AB_CDEF, '0, 13,
			32'h0100_0000, 1'b0, REJECT));
		plan.push_back(row(OP_ENQ, 32'h7000_0000, '1, '0, 1, '0, 1'b1, REJECT));
		plan.push_back(row(OP_ENQ, '0, 64'h0F0F_0F0F_0F0F_0F0F, '0, 1, '0, 1'b1,
			res(1'b1, '0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1)));
		plan.push_back(row(OP_RNG, '0, '0, '1, 1, '0, 1'b0, REJECT));
		plan.push_back(row(OP_NOP, '0, '0, '0, 1, '0, 1'b1, REJECT));
		plan.push_back(row(OP_DEQ, '0, '0, '0, 1, '0, 1'b1, res(1'b1, '1, '1, 1'b1)));

		foreach (plan[p])
			for (int j = 0; j < plan[p].reps; j++) begin
				r = plan[p];
				r.key = plan[p].key + plan[p].stride * j;
				r.value = plan[p].value ^ VAL_W'(j);
				send_req(r);
				maybe_gap();
			end

		// Random requests
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 20)
				hold_request = 1'b1;
			if (i == 90) begin
				// pause until everything in flight has come back
				s_tvalid <= 1'b0;
				wait (expected_q.size() == 0);
				@(negedge clk);
			end
			if (i >= 110)
				no_idle = 1'b1;
			send_req(rand_req((i < 60) ? 0 : (i < 110) ? 1 : 2));
			maybe_gap();
		end
		s_tvalid <= 1'b0;

		// Drain and close
		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			report("results still expected", VAL_W'(expected_q.size()), '0);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
